/* hdl/lpsc_pkg.sv */
package lpsc_pkg;

  // Opening bytes held back before the unit is classified
  localparam int HOLD = 7;
  // Most results that one input beat can raise
  localparam int MAX_RESULTS = 7;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum logic [1:0] {
    MODE_DECIDING,
    MODE_PASS,
    MODE_CONVERT,
    MODE_DROP
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_CONVERTED,
    STATUS_PASSED,
    STATUS_ERROR
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    status_t    status;
  } res_t;

  function automatic res_t make_res(logic [7:0] data, logic has_byte, logic last,
                                    status_t status);
    res_t r;
    r.data     = data;
    r.has_byte = has_byte;
    r.last     = last;
    r.status   = status;
    return r;
  endfunction

  function automatic res_t error_res();
    return make_res(8'h00, 1'b0, 1'b1, STATUS_ERROR);
  endfunction

endpackage

/* hdl/lpsc_if.sv */
interface lpsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface lpsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, out_byte, has_byte, out_last, status, input ready);
  modport sink (input valid, out_byte, has_byte, out_last, status, output ready);
endinterface

/* hdl/length_prefix_to_start_code_top.sv */
// Length-prefix to start-code converter for one access unit at a time.
// upstream carries the bytes of an access unit, in_last on the final beat.
// downstream carries the result beats: out_byte when has_byte is set, and
// out_last with status (converted, passed through, format error) on the
// final result of each unit.
// The first seven bytes of a unit are held; on the seventh (or on a shorter
// unit's last byte) the unit is classified and up to seven results are
// raised by that beat. Every other byte raises at most five results.
// Results go through a 16-entry result queue; a result appears on
// downstream in the cycle after the beat that raised it when the queue is empty.
// Throughput is one byte per cycle in and one result per cycle out while
// nothing stalls. upstream ready is set while the queue has room for seven
// more results, so a downstream stall fills the queue and then holds
// upstream off; nothing is lost or repeated.
// Reset empties the queue and returns the unit state to the start of an
// access unit. No clearing pass is needed.
module length_prefix_to_start_code_top (
  input  logic              clk,
  input  logic              rst,
  lpsc_in_if.sink           upstream,
  lpsc_out_if.source        downstream
);

  // unit state
  logic [7:0]         held [lpsc_pkg::HOLD];
  logic [2:0]         held_count, held_count_next;
  lpsc_pkg::mode_t    mode, mode_next;
  logic [1:0]         hdr_pos, hdr_pos_next;
  logic [31:0]        len_acc, len_acc_next;
  logic [31:0]        payload_left, payload_left_next;

  // result queue
  lpsc_pkg::res_t                fifo_mem [lpsc_pkg::FIFO_DEPTH];
  logic [lpsc_pkg::PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [lpsc_pkg::CNT_W-1:0]    fifo_count;

  logic        accept, pop;
  logic [7:0]  b;
  logic        lst;

  logic [7:0]  win [lpsc_pkg::HOLD];
  logic [3:0]  n4;
  logic        start_found;
  logic        short_ok;
  logic [31:0] hl_len;
  logic        len_zero;
  logic [1:0]  take;
  logic        pl_nz;
  logic [31:0] acc_shift;
  logic        hdr_done;
  logic        emit_sc;

  lpsc_pkg::res_t res [lpsc_pkg::MAX_RESULTS];
  logic [2:0]     res_cnt;

  assign accept = upstream.valid && upstream.ready;
  assign pop    = downstream.valid && downstream.ready;
  assign b      = upstream.in_byte;
  assign lst    = upstream.in_last;

  assign upstream.ready = fifo_count <=
                          lpsc_pkg::CNT_W'(lpsc_pkg::FIFO_DEPTH - lpsc_pkg::MAX_RESULTS);

  // ---------------------------------------------------------------- decode
  always_comb begin
    for (int i = 0; i < lpsc_pkg::HOLD; i++) begin
      win[i] = (held_count == 3'(i)) ? b : held[i];
    end
  end

  assign n4 = {1'b0, held_count} + 4'd1;

  // start code at offsets 0..3, only where it fits in the bytes seen
  always_comb begin
    start_found = 1'b0;
    for (int o = 0; o < 4; o++) begin
      if (4'(o + 4) <= n4 && win[o] == 8'h00 && win[o+1] == 8'h00 &&
          win[o+2] == 8'h00 && win[o+3] == 8'h01) begin
        start_found = 1'b1;
      end
      if (4'(o + 3) <= n4 && win[o] == 8'h00 && win[o+1] == 8'h00 &&
          win[o+2] == 8'h01) begin
        start_found = 1'b1;
      end
    end
  end

  assign hl_len   = {win[0], win[1], win[2], win[3]};
  assign len_zero = hl_len == 32'd0;
  assign short_ok = n4 >= 4'd5 && win[0] == 8'h00 && win[1] == 8'h00 &&
                    win[2] == 8'h00 && win[3] == {4'd0, n4 - 4'd4};
  // payload bytes among the three that follow the first prefix
  assign take     = (hl_len >= 32'd3) ? 2'd3 : hl_len[1:0];

  assign pl_nz     = payload_left != 32'd0;
  assign acc_shift = {len_acc[23:0], b};
  assign hdr_done  = hdr_pos == 2'd3;
  assign emit_sc   = !pl_nz && hdr_done && acc_shift != 32'd0;

  // ------------------------------------------------------------ next state
  always_comb begin
    held_count_next   = held_count;
    mode_next         = mode;
    hdr_pos_next      = hdr_pos;
    len_acc_next      = len_acc;
    payload_left_next = payload_left;
    if (accept) begin
      if (lst) begin
        held_count_next   = 3'd0;
        mode_next         = lpsc_pkg::MODE_DECIDING;
        hdr_pos_next      = 2'd0;
        len_acc_next      = 32'd0;
        payload_left_next = 32'd0;
      end else begin
        case (mode)
          lpsc_pkg::MODE_DECIDING: begin
            held_count_next = n4[2:0];
            if (n4 == 4'(lpsc_pkg::HOLD)) begin
              if (start_found) begin
                mode_next = lpsc_pkg::MODE_PASS;
              end else if (len_zero) begin
                mode_next = lpsc_pkg::MODE_DROP;
              end else begin
                mode_next         = lpsc_pkg::MODE_CONVERT;
                payload_left_next = hl_len - {30'd0, take};
                hdr_pos_next      = 2'd3 - take;
                case (take)
                  2'd1:    len_acc_next = {16'd0, win[5], win[6]};
                  2'd2:    len_acc_next = {24'd0, win[6]};
                  default: len_acc_next = 32'd0;
                endcase
              end
            end
          end
          lpsc_pkg::MODE_CONVERT: begin
            if (pl_nz) begin
              payload_left_next = payload_left - 32'd1;
            end else if (hdr_done) begin
              hdr_pos_next = 2'd0;
              len_acc_next = 32'd0;
              if (acc_shift == 32'd0) begin
                mode_next = lpsc_pkg::MODE_DROP;
              end else begin
                payload_left_next = acc_shift;
              end
            end else begin
              len_acc_next = acc_shift;
              hdr_pos_next = hdr_pos + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------- results
  always_comb begin
    for (int i = 0; i < lpsc_pkg::MAX_RESULTS; i++) begin
      res[i] = lpsc_pkg::make_res(8'h00, 1'b0, 1'b0, lpsc_pkg::STATUS_CONVERTED);
    end
    res_cnt = 3'd0;
    case (mode)
      lpsc_pkg::MODE_DECIDING: begin
        if (lst || n4 == 4'(lpsc_pkg::HOLD)) begin
          if (start_found) begin
            for (int i = 0; i < lpsc_pkg::HOLD; i++) begin
              res[i] = lpsc_pkg::make_res(win[i], 1'b1, lst && held_count == 3'(i),
                         (lst && held_count == 3'(i)) ? lpsc_pkg::STATUS_PASSED
                                                      : lpsc_pkg::STATUS_CONVERTED);
            end
            res_cnt = n4[2:0];
          end else if (lst) begin
            if (short_ok) begin
              for (int i = 0; i < 4; i++) begin
                res[i] = lpsc_pkg::make_res(lpsc_pkg::START_CODE[i], 1'b1, 1'b0,
                                            lpsc_pkg::STATUS_CONVERTED);
              end
              for (int i = 4; i < lpsc_pkg::HOLD; i++) begin
                res[i] = lpsc_pkg::make_res(win[i], 1'b1, held_count == 3'(i),
                                            lpsc_pkg::STATUS_CONVERTED);
              end
              res_cnt = n4[2:0];
            end else begin
              res[0]  = lpsc_pkg::error_res();
              res_cnt = 3'd1;
            end
          end else if (!len_zero) begin
            for (int i = 0; i < 4; i++) begin
              res[i] = lpsc_pkg::make_res(lpsc_pkg::START_CODE[i], 1'b1, 1'b0,
                                          lpsc_pkg::STATUS_CONVERTED);
            end
            for (int i = 4; i < lpsc_pkg::HOLD; i++) begin
              res[i] = lpsc_pkg::make_res(win[i], 1'b1, 1'b0, lpsc_pkg::STATUS_CONVERTED);
            end
            res_cnt = 3'd4 + {1'b0, take};
          end
        end
      end
      lpsc_pkg::MODE_PASS: begin
        res[0]  = lpsc_pkg::make_res(b, 1'b1, lst,
                    lst ? lpsc_pkg::STATUS_PASSED : lpsc_pkg::STATUS_CONVERTED);
        res_cnt = 3'd1;
      end
      lpsc_pkg::MODE_CONVERT: begin
        if (pl_nz) begin
          // a unit that ends on the final payload byte closes cleanly; an earlier end is an error
          res[0]  = lpsc_pkg::make_res(b, 1'b1, lst && payload_left == 32'd1,
                                       lpsc_pkg::STATUS_CONVERTED);
          res_cnt = 3'd1;
          if (lst && payload_left != 32'd1) begin
            res[1]  = lpsc_pkg::error_res();
            res_cnt = 3'd2;
          end
        end else if (emit_sc) begin
          for (int i = 0; i < 4; i++) begin
            res[i] = lpsc_pkg::make_res(lpsc_pkg::START_CODE[i], 1'b1, 1'b0,
                                        lpsc_pkg::STATUS_CONVERTED);
          end
          res_cnt = 3'd4;
          if (lst) begin
            res[4]  = lpsc_pkg::error_res();
            res_cnt = 3'd5;
          end
        end else if (lst) begin
          res[0]  = lpsc_pkg::error_res();
          res_cnt = 3'd1;
        end
      end
      lpsc_pkg::MODE_DROP: begin
        if (lst) begin
          res[0]  = lpsc_pkg::error_res();
          res_cnt = 3'd1;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 3'd0;
      mode         <= lpsc_pkg::MODE_DECIDING;
      hdr_pos      <= 2'd0;
      len_acc      <= 32'd0;
      payload_left <= 32'd0;
    end else begin
      held_count   <= held_count_next;
      mode         <= mode_next;
      hdr_pos      <= hdr_pos_next;
      len_acc      <= len_acc_next;
      payload_left <= payload_left_next;
    end
  end

  // hold the opening bytes
  always_ff @(posedge clk) begin
    if (accept && mode == lpsc_pkg::MODE_DECIDING && !lst) begin
      held[held_count] <= b;
    end
  end

  // ----------------------------------------------------------- result queue
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < lpsc_pkg::MAX_RESULTS; i++) begin
        if (3'(i) < res_cnt) begin
          fifo_mem[wr_ptr + lpsc_pkg::PTR_W'(i)] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + lpsc_pkg::PTR_W'(res_cnt);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lpsc_pkg::PTR_W'(1);
      end
      fifo_count <= fifo_count
                    + (accept ? lpsc_pkg::CNT_W'(res_cnt) : lpsc_pkg::CNT_W'(0))
                    - (pop ? lpsc_pkg::CNT_W'(1) : lpsc_pkg::CNT_W'(0));
    end
  end

  assign downstream.valid    = fifo_count != '0;
  assign downstream.out_byte = fifo_mem[rd_ptr].data;
  assign downstream.has_byte = fifo_mem[rd_ptr].has_byte;
  assign downstream.out_last = fifo_mem[rd_ptr].last;
  assign downstream.status   = fifo_mem[rd_ptr].status;

  // ------------------------------------------------------------ assertions
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= lpsc_pkg::CNT_W'(lpsc_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_decided_full: assert property (@(posedge clk) disable iff (rst)
    mode != lpsc_pkg::MODE_DECIDING |-> held_count == 3'(lpsc_pkg::HOLD))
    else $error("unit classified before seven bytes were held");

  a_payload_no_hdr: assert property (@(posedge clk) disable iff (rst)
    mode == lpsc_pkg::MODE_CONVERT && payload_left != 32'd0 |-> hdr_pos == 2'd0)
    else $error("length prefix in progress while payload remains");

  a_unit_end_clear: assert property (@(posedge clk) disable iff (rst)
    accept && lst |=> mode == lpsc_pkg::MODE_DECIDING && held_count == 3'd0)
    else $error("unit state not cleared after final beat");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    downstream.valid && !downstream.has_byte |->
      downstream.out_last && downstream.status == lpsc_pkg::STATUS_ERROR)
    else $error("status-only result that is not a final error");

endmodule
